// ===== hdl/ptf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptf_pkg;

  localparam int unsigned RingLen = 5;

  localparam logic [7:0] CountTop     = 8'd180;
  localparam logic [7:0] CountWrap    = 8'd6;
  localparam logic [7:0] CountBase    = 8'd5;
  localparam logic [7:0] CountWarm    = 8'd35;
  localparam logic [7:0] CountHour1   = 8'd60;
  localparam logic [7:0] CountHour15  = 8'd95;
  localparam logic [7:0] CountTwoHour = 8'd120;
  localparam logic [7:0] CountHour25  = 8'd155;

  localparam logic [2:0] ClsStable   = 3'd0;
  localparam logic [2:0] ClsSlowRise = 3'd1;
  localparam logic [2:0] ClsSlowFall = 3'd2;
  localparam logic [2:0] ClsFastRise = 3'd3;
  localparam logic [2:0] ClsFastFall = 3'd4;
  localparam logic [2:0] ClsUnknown  = 3'd5;

  localparam logic CfgFast = 1'b0;
  localparam logic CfgSlow = 1'b1;

  localparam logic [15:0] CfgFastReset = 16'd250;
  localparam logic [15:0] CfgSlowReset = 16'd50;

  // floor(x / 5) == (x * 838861) >> 22 for any five-sample sum
  localparam logic [19:0] MeanMul   = 20'd838861;
  localparam int unsigned MeanShift = 22;

  // ceil(2^21 / d), exact truncation for magnitudes below 2^18
  localparam int unsigned RecipShift   = 21;
  localparam logic [21:0] RecipOne     = 22'd2097152;
  localparam logic [21:0] RecipHalf    = 22'd1048576;
  localparam logic [21:0] RecipQuarter = 22'd524288;
  localparam logic [21:0] RecipThird   = 22'd699051;
  localparam logic [21:0] RecipFifth   = 22'd419431;
  localparam logic [21:0] RecipSeventh = 22'd299594;

  typedef struct packed {
    logic acc;
    logic ld2;
    logic ld3;
    logic ldo;
  } pipe_en_t;

  typedef struct packed {
    logic [7:0]  cnt;
    logic [19:0] sum;
  } sum_beat_t;

  typedef struct packed {
    logic [7:0]  cnt;
    logic [16:0] mean;
  } mean_beat_t;

  typedef struct packed {
    logic        upd;
    logic        neg;
    logic        warm;
    logic [39:0] prod;
  } scale_beat_t;

  typedef struct packed {
    logic        hit;
    logic        dbl;
    logic [21:0] recip;
  } scale_sel_t;

  function automatic scale_sel_t scale_sel(input logic [7:0] cnt, input logic first);
    scale_sel_t s;
    s     = '0;
    s.hit = 1'b1;
    case (cnt)
      CountWarm: begin
        s.dbl   = 1'b1;
        s.recip = first ? RecipOne : RecipThird;
      end
      CountHour1: begin
        s.recip = first ? RecipOne : RecipHalf;
      end
      CountHour15: begin
        s.dbl   = 1'b1;
        s.recip = first ? RecipThird : RecipFifth;
      end
      CountTwoHour: begin
        s.recip = first ? RecipHalf : RecipThird;
      end
      CountHour25: begin
        s.dbl   = 1'b1;
        s.recip = first ? RecipFifth : RecipSeventh;
      end
      CountTop: begin
        s.recip = first ? RecipThird : RecipQuarter;
      end
      default: begin
        s.hit = 1'b0;
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ptf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptf_front import ptf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire pipe_en_t    en_i,
  input  wire logic [16:0] pressure_pa_i,
  output mean_beat_t       mean_o
);

  logic [16:0] ring_q [RingLen];
  logic [2:0]  slot_q, slot_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [19:0] run_sum_q, sum_d;
  sum_beat_t   s1_q;
  mean_beat_t  s2_q;
  logic [39:0] mean_prod;

  // running sum: drop the slot being overwritten, add the new sample
  always_comb begin
    sum_d  = run_sum_q - 20'(ring_q[slot_q]) + 20'(pressure_pa_i);
    cnt_d  = (cnt_q == CountTop) ? CountWrap : cnt_q + 8'd1;
    slot_d = (slot_q == 3'(RingLen - 1)) ? 3'd0 : slot_q + 3'd1;
  end

  assign mean_prod = 40'(s1_q.sum) * 40'(MeanMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RingLen; i++) begin
        ring_q[i] <= '0;
      end
      slot_q    <= '0;
      cnt_q     <= '0;
      run_sum_q <= '0;
    end else if (en_i.acc) begin
      ring_q[slot_q] <= pressure_pa_i;
      slot_q         <= slot_d;
      cnt_q          <= cnt_d;
      run_sum_q      <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.acc) begin
      s1_q.cnt <= cnt_d;
      s1_q.sum <= sum_d;
    end
    if (en_i.ld2) begin
      s2_q.cnt  <= s1_q.cnt;
      s2_q.mean <= mean_prod[MeanShift +: 17];
    end
  end

  assign mean_o = s2_q;

endmodule

`default_nettype wire

// ===== hdl/ptf_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptf_scale import ptf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pipe_en_t   en_i,
  input  wire mean_beat_t mean_i,
  output scale_beat_t     scale_o
);

  logic [16:0]       base_q;
  logic [16:0]       two_hour_q;
  logic              first_q;
  scale_sel_t        sel;
  logic signed [17:0] change;
  logic [16:0]       abs_change;
  logic [17:0]       mag;
  logic [39:0]       prod;
  scale_beat_t       s3_q;

  always_comb begin
    sel        = scale_sel(mean_i.cnt, first_q);
    change     = $signed({1'b0, mean_i.mean}) - $signed({1'b0, base_q});
    abs_change = change[17] ? 17'(-change) : change[16:0];
    mag        = sel.dbl ? {abs_change, 1'b0} : {1'b0, abs_change};
    prod       = 40'(mag) * 40'(sel.recip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      two_hour_q <= '0;
      first_q    <= 1'b1;
    end else if (en_i.ld3) begin
      if (mean_i.cnt == CountBase) begin
        base_q <= mean_i.mean;
      end
      if (mean_i.cnt == CountTwoHour) begin
        two_hour_q <= mean_i.mean;
      end
      if (mean_i.cnt == CountTop) begin
        base_q  <= two_hour_q;
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld3) begin
      s3_q.upd  <= sel.hit;
      s3_q.neg  <= change[17];
      s3_q.warm <= (mean_i.cnt < CountWarm) && first_q;
      s3_q.prod <= prod;
    end
  end

  assign scale_o = s3_q;

endmodule

`default_nettype wire

// ===== hdl/ptf_class.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptf_class import ptf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire pipe_en_t    en_i,
  input  wire scale_beat_t scale_i,
  input  wire logic [15:0] fast_i,
  input  wire logic [15:0] slow_i,
  output logic [2:0]       weather_class_o,
  output logic signed [18:0] pressure_trend_o
);

  logic signed [18:0] trend_q, trend_d, trend_new;
  logic [17:0]        quot;
  logic signed [19:0] t, f_pos, f_neg, s_pos, s_neg;
  logic [2:0]         wclass;
  logic [2:0]         wclass_q;
  logic signed [18:0] trend_out_q;

  always_comb begin
    quot      = scale_i.prod[RecipShift +: 18];
    trend_new = scale_i.neg ? -$signed(19'(quot)) : $signed(19'(quot));
    trend_d   = scale_i.upd ? trend_new : trend_q;

    t     = 20'(trend_d);
    f_pos = $signed({4'b0, fast_i});
    f_neg = -f_pos;
    s_pos = $signed({4'b0, slow_i});
    s_neg = -s_pos;

    if (scale_i.warm) begin
      wclass = ClsUnknown;
    end else if (t < f_neg) begin
      wclass = ClsFastFall;
    end else if (t > f_pos) begin
      wclass = ClsFastRise;
    end else if (t > f_neg && t < s_neg) begin
      wclass = ClsSlowFall;
    end else if (t > s_pos && t < f_pos) begin
      wclass = ClsSlowRise;
    end else if (t > s_neg && t < s_pos) begin
      wclass = ClsStable;
    end else begin
      wclass = ClsUnknown;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trend_q <= '0;
    end else if (en_i.ldo) begin
      trend_q <= trend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ldo) begin
      wclass_q    <= wclass;
      trend_out_q <= trend_d;
    end
  end

  assign weather_class_o  = wclass_q;
  assign pressure_trend_o = trend_out_q;

endmodule

`default_nettype wire

// ===== hdl/pressure_trend_forecaster.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Barometric trend forecaster, one pressure sample per beat (nominally one a minute).
// A five-sample running mean is tracked against a base average over a three-hour
// window, and at minutes 35, 60, 95, 120, 155 and 180 the trend in Pa per hour is
// refreshed; every sample returns a forecast class with the current trend. The
// pipeline is four registers deep (running sum, mean multiply, reciprocal scaling,
// classification into the output register) and takes a new sample every cycle unless
// the output stalls; the output register alone sets backpressure. Thresholds are to be
// written on the cfg port only while idle, which the block does not enforce; they reset
// to 250 (fast) and 50 (slow). Class 5 is reported for the first 34 samples after reset.

module pressure_trend_forecaster import ptf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [16:0] pressure_pa_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       weather_class_o,
  output logic signed [18:0] pressure_trend_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  logic        v1_q, v2_q, v3_q, vo_q;
  logic        en2, en3, en_out;
  pipe_en_t    en;
  logic [15:0] fast_q, slow_q;
  mean_beat_t  mean_beat;
  scale_beat_t scale_beat;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    en_out  = !vo_q || out_ready_i;
    en3     = !v3_q || en_out;
    en2     = !v2_q || en3;
    in_ready_o = !v1_q || en2;
    en.acc  = in_valid_i && in_ready_o;
    en.ld2  = v1_q && en2;
    en.ld3  = v2_q && en3;
    en.ldo  = v3_q && en_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= en.acc || (v1_q && !en2);
      v2_q <= en.ld2 || (v2_q && !en3);
      v3_q <= en.ld3 || (v3_q && !en_out);
      vo_q <= en.ldo || (vo_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= CfgFastReset;
      slow_q <= CfgSlowReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFast: fast_q <= cfg_data_i;
        CfgSlow: slow_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ptf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .pressure_pa_i(pressure_pa_i),
    .mean_o       (mean_beat)
  );

  ptf_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .mean_i (mean_beat),
    .scale_o(scale_beat)
  );

  ptf_class u_class (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .scale_i         (scale_beat),
    .fast_i          (fast_q),
    .slow_i          (slow_q),
    .weather_class_o (weather_class_o),
    .pressure_trend_o(pressure_trend_o)
  );

  assign out_valid_o = vo_q;

endmodule

`default_nettype wire

// ===== hdl/ptf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptf_checker import ptf_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  weather_class_o,
  input wire logic signed [18:0] pressure_trend_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(weather_class_o)
      && $stable(pressure_trend_o))
    else $error("stalled result beat changed");

  // input side only stalls when the whole pipe is blocked by the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (weather_class_o == ClsFastRise || weather_class_o == ClsSlowRise)
      |-> pressure_trend_o > 0)
    else $error("rise class with non-positive trend");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (weather_class_o == ClsFastFall || weather_class_o == ClsSlowFall)
      |-> pressure_trend_o < 0)
    else $error("fall class with non-negative trend");

endmodule

bind pressure_trend_forecaster ptf_checker u_ptf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .weather_class_o (weather_class_o),
  .pressure_trend_o(pressure_trend_o)
);

`default_nettype wire

// ===== test/pressure_trend_forecaster_tb.sv =====
`timescale 1ns / 1ps

module pressure_trend_forecaster_tb;
  import ptf_pkg::*;

  localparam int PaMax       = 131071;
  localparam int RestPa      = 101325;
  localparam int ItemsTarget = 1350;
  localparam int QuietLimit  = 2000;
  localparam int ReportCap   = 40;

  typedef enum int {ReadyAlways, ReadyRandom, ReadyPattern, ReadyLazy} ready_mode_e;

  typedef struct packed {
    logic [2:0]  cls;
    logic [18:0] trend;
  } forecast_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [16:0] pressure_pa_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  weather_class_o;
  logic signed [18:0] pressure_trend_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  pressure_trend_forecaster dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pressure_pa_i    (pressure_pa_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .weather_class_o  (weather_class_o),
    .pressure_trend_o (pressure_trend_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  // forecaster state as the testbench sees it
  logic [16:0] ring_pa [RingLen];
  logic [7:0]  minute;
  bit          first_window;
  logic [16:0] base_avg;
  logic [16:0] two_hour_avg;
  int          trend_pa;
  logic [15:0] fast_thr;
  logic [15:0] slow_thr;

  forecast_t   forecast_q[$];
  int          fail_count;
  int          sample_count;
  int          burst_left;
  int          level;
  int          quiet_cycles;
  ready_mode_e ready_mode;
  int          mode_left;
  int          pattern_cnt;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void reset_forecast();
    for (int k = 0; k < RingLen; k++) ring_pa[k] = '0;
    minute       = '0;
    first_window = 1'b1;
    base_avg     = '0;
    two_hour_avg = '0;
    trend_pa     = 0;
    fast_thr     = CfgFastReset;
    slow_thr     = CfgSlowReset;
  endfunction

  function automatic void predict_forecast(input logic [16:0] pa);
    int unsigned total;
    logic [16:0] mean;
    int          change;
    int          fast;
    int          slow;
    forecast_t   want;
    ring_pa[minute % RingLen] = pa;
    total = 0;
    for (int k = 0; k < RingLen; k++) total += ring_pa[k];
    mean   = 17'(total / RingLen);
    minute = minute + 8'd1;
    if (minute > CountTop) minute = CountWrap;
    change = int'({15'd0, mean}) - int'({15'd0, base_avg});
    case (minute)
      CountBase:   base_avg = mean;
      CountWarm:   trend_pa = first_window ? change * 2 : (change * 2) / 3;
      CountHour1:  trend_pa = first_window ? change : change / 2;
      CountHour15: trend_pa = first_window ? (change * 2) / 3 : (change * 2) / 5;
      CountTwoHour: begin
        two_hour_avg = mean;
        trend_pa     = first_window ? change / 2 : change / 3;
      end
      CountHour25: trend_pa = first_window ? (change * 2) / 5 : (change * 2) / 7;
      CountTop: begin
        trend_pa     = first_window ? change / 3 : change / 4;
        base_avg     = two_hour_avg;
        first_window = 1'b0;
      end
      default: ;
    endcase
    fast = int'({16'd0, fast_thr});
    slow = int'({16'd0, slow_thr});
    if (minute < CountWarm && first_window) want.cls = ClsUnknown;
    else if (trend_pa < -fast) want.cls = ClsFastFall;
    else if (trend_pa > fast) want.cls = ClsFastRise;
    else if (trend_pa > -fast && trend_pa < -slow) want.cls = ClsSlowFall;
    else if (trend_pa > slow && trend_pa < fast) want.cls = ClsSlowRise;
    else if (trend_pa > -slow && trend_pa < slow) want.cls = ClsStable;
    else want.cls = ClsUnknown;
    want.trend = trend_pa[18:0];
    forecast_q.push_back(want);
  endfunction

  function automatic int clamp_pa(input int v);
    if (v < 0) return 0;
    if (v > PaMax) return PaMax;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    if (fail_count < ReportCap)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
    fail_count++;
  endtask

  // one result beat per accepted sample, checked against the oldest forecast
  always @(posedge clk_i) begin : check_beat
    forecast_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (forecast_q.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 1);
      end else begin
        want = forecast_q.pop_front();
        if (weather_class_o !== want.cls)
          report_mismatch("weather_class", want.cls, weather_class_o);
        if (pressure_trend_o !== $signed(want.trend))
          report_mismatch("pressure_trend", $signed(want.trend), pressure_trend_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver stalls, switching between several patterns
  always @(posedge clk_i) begin
    pattern_cnt <= pattern_cnt + 1;
    if (mode_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      ReadyAlways:  out_ready_i <= 1'b1;
      ReadyRandom:  out_ready_i <= ($urandom_range(0, 3) != 0);
      ReadyPattern: out_ready_i <= (pattern_cnt % 8 < 3);
      default:      out_ready_i <= ($urandom_range(0, 7) == 0) ? ~out_ready_i : out_ready_i;
    endcase
  end

  task automatic send_sample(input logic [16:0] pa);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    pressure_pa_i <= pa;
    do @(posedge clk_i); while (!in_ready_o);
    predict_forecast(pa);
    burst_left--;
    sample_count++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (forecast_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_thresholds(input logic [15:0] fast, input logic [15:0] slow);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgFast;
    cfg_data_i <= fast;
    @(posedge clk_i);
    cfg_idx_i  <= CfgSlow;
    cfg_data_i <= slow;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    fast_thr = fast;
    slow_thr = slow;
  endtask

  task automatic send_drift(input int n, input int slope, input int jitter);
    for (int i = 0; i < n; i++) begin
      level = clamp_pa(level + slope);
      send_sample(17'(clamp_pa(level + int'($urandom_range(0, 2 * jitter)) - jitter)));
    end
  endtask

  task automatic send_segment(input bit rough);
    int n;
    int kind;
    n    = $urandom_range(10, 60);
    kind = rough ? $urandom_range(0, 9) : 0;
    case (kind)
      7: for (int i = 0; i < n; i++) send_sample(17'($urandom_range(0, PaMax)));
      8: begin
        level = $urandom_range(0, 1) ? PaMax : 0;
        send_drift(n, 0, 0);
      end
      9: begin
        level = $urandom_range(60000, 125000);
        send_drift(n, int'($urandom_range(0, 16)) - 8, 1);
      end
      default: send_drift(n, int'($urandom_range(0, 20)) - 10, $urandom_range(0, 4));
    endcase
  endtask

  task automatic test_warmup_extremes();
    for (int i = 0; i < 5; i++) send_sample(17'(RestPa + i));
    send_sample(17'd0);
    send_sample(17'(PaMax));
    for (int b = 0; b < 17; b++) send_sample(17'd1 << b);
    send_sample(17'h15555);
    send_sample(17'h0AAAA);
  endtask

  task automatic test_trend_sweep();
    write_thresholds(CfgFastReset, CfgSlowReset);
    level = RestPa;
    repeat (10) send_segment(1'b0);
  endtask

  // thresholds placed exactly on the current trend magnitude
  task automatic test_threshold_edges();
    int mag;
    for (int k = 0; k < 8; k++) begin
      send_drift($urandom_range(20, 40), int'($urandom_range(0, 16)) - 8, 2);
      wait_idle();
      mag = (trend_pa < 0) ? -trend_pa : trend_pa;
      if (mag > 65535) mag = 65535;
      if (k % 2 == 0) write_thresholds(16'(mag), 16'(mag / 2));
      else write_thresholds(16'((mag * 2 + 1 > 65535) ? 65535 : mag * 2 + 1), 16'(mag));
      send_drift(12, 0, 0);
    end
  endtask

  task automatic test_threshold_extremes();
    int fast;
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: write_thresholds(16'd0, 16'd0);
        1: write_thresholds(16'hFFFF, 16'hFFFF);
        2: write_thresholds(16'd0, 16'hFFFF);
        3: write_thresholds(16'hFFFF, 16'd0);
        default: begin
          fast = $urandom_range(0, 300);
          write_thresholds(16'(fast), 16'(fast + int'($urandom_range(1, 300))));
        end
      endcase
      send_segment(1'b1);
      send_segment(1'b0);
    end
  endtask

  task automatic test_random_weather();
    int fast;
    while (sample_count < ItemsTarget) begin
      if ($urandom_range(0, 3) == 0) begin
        write_thresholds(16'($urandom), 16'($urandom));
      end else begin
        fast = $urandom_range(20, 700);
        write_thresholds(16'(fast), 16'($urandom_range(0, fast)));
      end
      repeat (4) send_segment(1'b1);
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    pressure_pa_i <= '0;
    out_ready_i   <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgFast;
    cfg_data_i    <= '0;
    ready_mode    = ReadyAlways;
    mode_left     = 0;
    pattern_cnt   = 0;
    quiet_cycles  = 0;
    fail_count    = 0;
    sample_count  = 0;
    burst_left    = 0;
    level         = RestPa;
    reset_forecast();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_warmup_extremes();
    test_trend_sweep();
    test_threshold_edges();
    test_threshold_extremes();
    test_random_weather();

    wait_idle();
    repeat (12) @(posedge clk_i);
    if (fail_count == 0 && forecast_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
